### sv/itda_pkg.sv
package itda_pkg;

  localparam int unsigned IN_VALUE_W = 32;
  localparam int unsigned LEN_W      = 4;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic                  is_signed;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       char_code;
    logic             last_char;
    logic [LEN_W-1:0] total_length;
  } out_item_t;

endpackage

### sv/int_to_decimal_ascii_unit.sv
// Decimal ASCII printer for one binary word per input transfer.
// Input channel: in_push / in_full carry in_data (the word and a signed flag).
// Result channel: in_data's characters leave most significant first on out_data,
// one transfer per character, while out_empty is low; out_pop takes one.
// A negative signed word gives a leading '-'; every character carries the
// total length of its number, and the final one has last_char set.
// The front end converts the word to decimal with a shift-and-add-three
// converter handling four bits a cycle. A two-entry queue separates it from
// the back end, which emits one character a cycle through an output register
// while the receiver keeps taking them, and loads each new number from the
// queue only when it is idle. The front end can take a new word as it hands
// the last one to the queue, so converting one number overlaps printing the
// one before.
// When the receiver stalls, the output register holds its character, the back
// end waits, the queue fills and in_full then rises; nothing is dropped.
// Reset clears the busy and valid flags, the step counter and the queue state, and leaves the channels empty.
module int_to_decimal_ascii_unit import itda_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  // Digit count of the largest magnitude: floor(W * log10(2)) + 1.
  localparam int unsigned NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned QW   = NDIG * 4 + 1;

  logic                 f_push;
  logic                 f_full;
  logic [NDIG-1:0][3:0] f_bcd;
  logic                 f_neg;
  logic                 b_pop;
  logic                 b_empty;
  logic [QW-1:0]        q_rdata;
  logic [NDIG-1:0][3:0] b_bcd;
  logic                 b_neg;

  assign b_neg = q_rdata[QW-1];
  assign b_bcd = q_rdata[QW-2:0];

  itda_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (f_push),
    .q_full  (f_full),
    .q_bcd   (f_bcd),
    .q_neg   (f_neg)
  );

  itda_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .full  (f_full),
    .wdata ({f_neg, f_bcd}),
    .pop   (b_pop),
    .empty (b_empty),
    .rdata (q_rdata)
  );

  itda_back #(
    .NDIG (NDIG)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (b_empty),
    .q_pop     (b_pop),
    .q_bcd     (b_bcd),
    .q_neg     (b_neg),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

### sv/itda_front.sv
module itda_front import itda_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NDIG        = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_item_t             in_data,
  output logic                 q_push,
  input  logic                 q_full,
  output logic [NDIG-1:0][3:0] q_bcd,
  output logic                 q_neg
);

  localparam int unsigned STEPS = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned PADW  = STEPS * 4;
  localparam int unsigned CW    = $clog2(STEPS + 1);
  localparam int unsigned BCDW  = NDIG * 4;

  logic                    busy_r, busy_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [PADW-1:0]         mag_r, mag_nxt;
  logic [NDIG-1:0][3:0]    bcd_r, bcd_nxt;
  logic                    neg_r, neg_nxt;

  logic [VALUE_WIDTH-1:0]  word;
  logic [VALUE_WIDTH-1:0]  mag;
  logic                    negative;
  logic                    accept;
  logic                    done;
  logic [PADW-1:0]         step_mag;
  logic [NDIG-1:0][3:0]    step_bcd;

  // The word is zero-extended or cut to the configured width.
  assign word     = VALUE_WIDTH'(in_data.value);
  assign negative = in_data.is_signed & word[VALUE_WIDTH-1];
  assign mag      = negative ? (~word + 1'b1) : word;

  assign done    = busy_r && (cnt_r == '0);
  assign q_push  = done && !q_full;
  assign in_full = busy_r && !q_push;
  assign accept  = in_push && !in_full;
  assign q_bcd   = bcd_r;
  assign q_neg   = neg_r;

  // Four double-dabble steps per cycle: correct each digit, then shift in one bit.
  always_comb begin
    step_mag = mag_r;
    step_bcd = bcd_r;
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < NDIG; i++) begin
        if (step_bcd[i] >= 4'd5) begin
          step_bcd[i] = step_bcd[i] + 4'd3;
        end
      end
      step_bcd = BCDW'({step_bcd, step_mag[PADW-1]});
      step_mag = step_mag << 1;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    neg_nxt  = neg_r;
    if (busy_r && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - 1'b1;
      mag_nxt = step_mag;
      bcd_nxt = step_bcd;
    end else if (q_push) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(STEPS);
      mag_nxt  = PADW'(mag);
      bcd_nxt  = '0;
      neg_nxt  = negative;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

endmodule

### sv/itda_queue.sv
module itda_queue #(
  parameter int unsigned WIDTH = 41
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  logic [1:0][WIDTH-1:0] mem_r;
  logic                  wp_r, wp_nxt;
  logic                  rp_r, rp_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

### sv/itda_back.sv
module itda_back import itda_pkg::*; #(
  parameter int unsigned NDIG = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [NDIG-1:0][3:0] q_bcd,
  input  logic                 q_neg,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_data
);

  localparam int unsigned DW = $clog2(NDIG);
  localparam int unsigned TW = ($clog2(NDIG + 2) > LEN_W) ? $clog2(NDIG + 2) : LEN_W;

  logic                 busy_r, busy_nxt;
  logic                 sign_r, sign_nxt;
  logic [DW-1:0]        d_r, d_nxt;
  logic [NDIG-1:0][3:0] bcd_r, bcd_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic                 ov_r, ov_nxt;
  out_item_t            out_r, out_nxt;

  logic [DW-1:0]        top;
  logic [TW-1:0]        total;
  logic                 emit;

  // Highest non-zero digit; zero itself prints as a single digit.
  always_comb begin
    top = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (q_bcd[i] != 4'd0) begin
        top = DW'(i);
      end
    end
  end

  assign total     = TW'(top) + TW'(1) + TW'(q_neg);
  assign q_pop     = !busy_r && !q_empty;
  assign emit      = busy_r && (!ov_r || out_pop);
  assign out_empty = !ov_r;
  assign out_data  = out_r;

  always_comb begin
    busy_nxt = busy_r;
    sign_nxt = sign_r;
    d_nxt    = d_r;
    bcd_nxt  = bcd_r;
    len_nxt  = len_r;
    out_nxt  = out_r;
    ov_nxt   = ov_r && !out_pop;
    if (q_pop) begin
      busy_nxt = 1'b1;
      sign_nxt = q_neg;
      d_nxt    = top;
      bcd_nxt  = q_bcd;
      len_nxt  = total[LEN_W-1:0];
    end
    if (emit) begin
      ov_nxt               = 1'b1;
      out_nxt.total_length = len_r;
      if (sign_r) begin
        out_nxt.char_code = ASCII_MINUS;
        out_nxt.last_char = 1'b0;
        sign_nxt          = 1'b0;
      end else begin
        out_nxt.char_code = ASCII_ZERO + {4'd0, bcd_r[d_r]};
        out_nxt.last_char = (d_r == '0);
        if (d_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          d_nxt = d_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    sign_r <= sign_nxt;
    d_r    <= d_nxt;
    bcd_r  <= bcd_nxt;
    len_r  <= len_nxt;
    out_r  <= out_nxt;
  end

endmodule
